/* src/mbde_pkg.sv */
// ----------------------------------------------------------------------------
// mbde_pkg: shared types and constants for the multi-button debounce block
// Item structs, per-button flag layout, configuration set and register codes.
// ----------------------------------------------------------------------------
package mbde_pkg;

    localparam int NUM_BUTTONS_DEF = 16;
    localparam int PIN_W           = 16;
    localparam int TIME_W          = 32;
    localparam int CFG_W           = 16;
    localparam int REG_IDX_W       = 3;

    // register index codes
    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HELD_UNTIL    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_UP_UNTIL      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TICK_INTERVAL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EVENT_ENABLE  = 3'd4;

    // register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd20;
    localparam logic [CFG_W-1:0] HELD_UNTIL_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] UP_UNTIL_RST      = 16'd1000;
    localparam logic [CFG_W-1:0] TICK_INTERVAL_RST = 16'd500;
    localparam logic [2:0]       EVENT_ENABLE_RST  = 3'd0;

    // event_enable bits
    localparam int EN_HELD_LONG = 0;
    localparam int EN_UP_LONG   = 1;
    localparam int EN_TICK      = 2;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_levels;
        logic [TIME_W-1:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic [PIN_W-1:0] level_mask;
        logic [PIN_W-1:0] fell_mask;
        logic [PIN_W-1:0] rose_mask;
        logic [PIN_W-1:0] up_mask;
        logic [PIN_W-1:0] held_mask;
        logic [PIN_W-1:0] held_long_mask;
        logic [PIN_W-1:0] up_long_mask;
        logic [PIN_W-1:0] tick_mask;
    } result_t;

    typedef struct packed {
        logic cur;
        logic stable;
        logic acc;
        logic chg;
        logic used;
        logic tick;
    } flags_t;

    localparam flags_t FLAGS_RST = '{cur: 1'b1, stable: 1'b1, acc: 1'b1,
                                     chg: 1'b0, used: 1'b0, tick: 1'b0};

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] held_until_ms;
        logic [CFG_W-1:0] up_until_ms;
        logic [CFG_W-1:0] tick_interval_ms;
        logic [2:0]       event_enable;
    } cfg_t;

    // per-button result bits from the evaluation unit
    typedef struct packed {
        logic lvl;
        logic fell;
        logic rose;
        logic up;
        logic held;
        logic held_long;
        logic up_long;
        logic tick;
    } evt_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

endpackage

/* src/mbde_unit.sv */
// ----------------------------------------------------------------------------
// mbde_unit: per-button debounce and event evaluation
// Updates one button's flags and timestamps and derives its event bits.
// ----------------------------------------------------------------------------
module mbde_unit (
    input  mbde_pkg::cfg_t                    cfg,
    input  mbde_pkg::flags_t                  flags,
    input  logic [mbde_pkg::TIME_W-1:0]       state_start,
    input  logic [mbde_pkg::TIME_W-1:0]       tick_start,
    input  logic [mbde_pkg::TIME_W-1:0]       now_ms,
    input  logic                              level,
    output mbde_pkg::flags_t                  flags_next,
    output logic [mbde_pkg::TIME_W-1:0]       state_start_next,
    output logic [mbde_pkg::TIME_W-1:0]       tick_start_next,
    output mbde_pkg::evt_t                    evt
);

    mbde_pkg::flags_t                  f;
    mbde_pkg::evt_t                    e;
    logic [mbde_pkg::TIME_W-1:0]       ss;
    logic [mbde_pkg::TIME_W-1:0]       ts;
    logic [mbde_pkg::TIME_W-1:0]       dur;
    logic [mbde_pkg::TIME_W-1:0]       since;
    logic [mbde_pkg::TIME_W-1:0]       interval;
    logic                              settled;

    always_comb
    begin
        f        = flags;
        ss       = state_start;
        ts       = tick_start;
        interval = {{(mbde_pkg::TIME_W-mbde_pkg::CFG_W){1'b0}}, cfg.tick_interval_ms};
        settled  = (now_ms - state_start) >=
                   {{(mbde_pkg::TIME_W-mbde_pkg::CFG_W){1'b0}}, cfg.debounce_ms};

        // debounce: drop the change flag, sample the level
        f.chg = 1'b0;
        f.cur = level;
        if (f.cur == f.acc)
        begin
            f.stable = 1'b1;
        end
        else if (f.stable)
        begin
            f.stable = 1'b0;
            ss       = now_ms;
        end
        else if (settled)
        begin
            f.stable = 1'b1;
            f.chg    = 1'b1;
            f.acc    = level;
            f.used   = 1'b0;
            ss       = now_ms;
            ts       = now_ms;
        end

        dur   = now_ms - ss;
        since = now_ms - ts;

        e.lvl  = f.acc;
        e.fell = !f.cur && f.stable && !f.acc && f.chg;
        e.rose = f.cur && f.stable && f.acc && f.chg;
        e.up   = f.cur && f.stable && f.acc && !f.chg;
        e.held = !f.cur && f.stable && !f.acc && !f.chg;

        e.held_long = cfg.event_enable[mbde_pkg::EN_HELD_LONG] && e.held && !f.used &&
                      (dur >= {{(mbde_pkg::TIME_W-mbde_pkg::CFG_W){1'b0}},
                               cfg.held_until_ms});
        if (e.held_long)
        begin
            f.used = 1'b1;
        end

        e.up_long = cfg.event_enable[mbde_pkg::EN_UP_LONG] && e.up && !f.used &&
                    (dur >= {{(mbde_pkg::TIME_W-mbde_pkg::CFG_W){1'b0}},
                             cfg.up_until_ms});
        if (e.up_long)
        begin
            f.used = 1'b1;
        end

        // repeat tick: fire once per interval, re-arm when below it
        e.tick = 1'b0;
        if (cfg.event_enable[mbde_pkg::EN_TICK] && e.held)
        begin
            if (since >= interval && !f.tick)
            begin
                f.tick = 1'b1;
                ts     = ts + interval;
                e.tick = 1'b1;
            end
            else if (since < interval && f.tick)
            begin
                f.tick = 1'b0;
            end
        end

        flags_next       = f;
        state_start_next = ss;
        tick_start_next  = ts;
        evt              = e;
    end

endmodule

/* src/multi_button_debounce_events_top.sv */
// ----------------------------------------------------------------------------
// multi_button_debounce_events_top: debounced multi-button event detector
// Debounces up to NUM_BUTTONS active-low buttons against a millisecond
// timestamp and reports level, edge, steady, long-press and repeat-tick masks.
// ----------------------------------------------------------------------------
//
//  channel | handshake                     | payload               | direction
//  --------+-------------------------------+-----------------------+----------
//  sample  | sample_valid / sample_ready   | mbde_pkg::sample_t    | in
//  result  | result_valid / result_ready   | mbde_pkg::result_t    | out
//  config  | wr_en (no wait)               | wr_index, wr_data     | in
//
//  An item is captured first, then each button is stepped in turn through the
//  shared evaluation unit, which is walked by a button counter.
//  The result register is loaded on the last button step; the next item can be
//  accepted in the following cycle even while that result still waits.
//  If the previous result is still held when the last button is reached, hold
//  that step until the result register frees up.
//  Reset (rst_n, asynchronous, active low) restores the register defaults and
//  puts every button in the released, stable, accepted state with zero times.
//
module multi_button_debounce_events_top #(
    parameter int NUM_BUTTONS = mbde_pkg::NUM_BUTTONS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  mbde_pkg::sample_t                  sample,

    output logic                               result_valid,
    input  logic                               result_ready,
    output mbde_pkg::result_t                  result,

    input  logic                               wr_en,
    input  logic [mbde_pkg::REG_IDX_W-1:0]     wr_index,
    input  logic [mbde_pkg::CFG_W-1:0]         wr_data
);

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUTTONS - 1);

    // configuration registers
    mbde_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms      <= mbde_pkg::DEBOUNCE_RST;
            cfg_reg.held_until_ms    <= mbde_pkg::HELD_UNTIL_RST;
            cfg_reg.up_until_ms      <= mbde_pkg::UP_UNTIL_RST;
            cfg_reg.tick_interval_ms <= mbde_pkg::TICK_INTERVAL_RST;
            cfg_reg.event_enable     <= mbde_pkg::EVENT_ENABLE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                mbde_pkg::REG_DEBOUNCE:      cfg_reg.debounce_ms      <= wr_data;
                mbde_pkg::REG_HELD_UNTIL:    cfg_reg.held_until_ms    <= wr_data;
                mbde_pkg::REG_UP_UNTIL:      cfg_reg.up_until_ms      <= wr_data;
                mbde_pkg::REG_TICK_INTERVAL: cfg_reg.tick_interval_ms <= wr_data;
                mbde_pkg::REG_EVENT_ENABLE:  cfg_reg.event_enable     <= wr_data[2:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    mbde_pkg::state_t                  state_reg, state_next;
    logic [IDX_W-1:0]                  cnt_reg, cnt_next;
    logic [mbde_pkg::PIN_W-1:0]        pins_reg, pins_next;
    logic [mbde_pkg::TIME_W-1:0]       now_reg;
    mbde_pkg::result_t                 acc_reg, acc_next;
    mbde_pkg::result_t                 result_reg;
    logic                              result_valid_reg, result_valid_next;

    // per-button state
    mbde_pkg::flags_t                  flags_reg [NUM_BUTTONS];
    logic [mbde_pkg::TIME_W-1:0]       ss_reg    [NUM_BUTTONS];
    logic [mbde_pkg::TIME_W-1:0]       ts_reg    [NUM_BUTTONS];

    mbde_pkg::flags_t                  u_flags_next;
    logic [mbde_pkg::TIME_W-1:0]       u_ss_next;
    logic [mbde_pkg::TIME_W-1:0]       u_ts_next;
    mbde_pkg::evt_t                    u_evt;

    logic                              accept;
    logic                              last;
    logic                              out_free;
    logic                              step;
    logic [mbde_pkg::PIN_W-1:0]        sel;

    assign sample_ready = (state_reg == mbde_pkg::ST_IDLE);
    assign accept       = sample_valid && sample_ready;
    assign last         = (cnt_reg == LAST_IDX);
    assign out_free     = !result_valid_reg || result_ready;
    // advance one button a cycle; hold the final button until the output frees
    assign step         = (state_reg == mbde_pkg::ST_RUN) && (!last || out_free);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // the shared evaluation unit sees the button picked by the counter;
    // pins_reg shifts right so bit 0 is always the current button, and buttons
    // past the pin width read released (ones shifted in)
    mbde_unit u_unit (
        .cfg              (cfg_reg),
        .flags            (flags_reg[cnt_reg]),
        .state_start      (ss_reg[cnt_reg]),
        .tick_start       (ts_reg[cnt_reg]),
        .now_ms           (now_reg),
        .level            (pins_reg[0]),
        .flags_next       (u_flags_next),
        .state_start_next (u_ss_next),
        .tick_start_next  (u_ts_next),
        .evt              (u_evt)
    );

    // one-hot lane select into the result masks; buttons past the pin width drop out
    always_comb
    begin
        for (int k = 0; k < mbde_pkg::PIN_W; k++)
        begin
            sel[k] = (k < NUM_BUTTONS) && (int'(cnt_reg) == k);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pins_next         = pins_reg;
        acc_next          = acc_reg;
        result_valid_next = result_valid_reg && !result_ready;

        if (accept)
        begin
            state_next = mbde_pkg::ST_RUN;
            cnt_next   = '0;
            pins_next  = sample.pin_levels;
            acc_next   = '0;
        end
        else if (step)
        begin
            pins_next               = {1'b1, pins_reg[mbde_pkg::PIN_W-1:1]};
            acc_next.level_mask     = acc_reg.level_mask     | (sel & {16{u_evt.lvl}});
            acc_next.fell_mask      = acc_reg.fell_mask      | (sel & {16{u_evt.fell}});
            acc_next.rose_mask      = acc_reg.rose_mask      | (sel & {16{u_evt.rose}});
            acc_next.up_mask        = acc_reg.up_mask        | (sel & {16{u_evt.up}});
            acc_next.held_mask      = acc_reg.held_mask      | (sel & {16{u_evt.held}});
            acc_next.held_long_mask = acc_reg.held_long_mask | (sel & {16{u_evt.held_long}});
            acc_next.up_long_mask   = acc_reg.up_long_mask   | (sel & {16{u_evt.up_long}});
            acc_next.tick_mask      = acc_reg.tick_mask      | (sel & {16{u_evt.tick}});
            if (last)
            begin
                state_next        = mbde_pkg::ST_IDLE;
                result_valid_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= mbde_pkg::ST_IDLE;
            cnt_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pins_reg <= pins_next;
        acc_reg  <= acc_next;
        if (accept)
        begin
            now_reg <= sample.now_ms;
        end
        if (step && last)
        begin
            result_reg <= acc_next;
        end
    end

    // per-button state: write back the evaluated button
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < NUM_BUTTONS; n++)
            begin
                flags_reg[n] <= mbde_pkg::FLAGS_RST;
                ss_reg[n]    <= '0;
                ts_reg[n]    <= '0;
            end
        end
        else if (step)
        begin
            flags_reg[cnt_reg] <= u_flags_next;
            ss_reg[cnt_reg]    <= u_ss_next;
            ts_reg[cnt_reg]    <= u_ts_next;
        end
    end

`ifndef SYNTHESIS
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == mbde_pkg::ST_RUN) && (cnt_reg == '0))
        else $error("item accepted without starting at the first button");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(state_reg) == mbde_pkg::ST_RUN) && $past(last))
        else $error("result raised outside the last button step");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        int'(cnt_reg) < NUM_BUTTONS)
        else $error("button counter beyond button count");

    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.fell_mask & result.rose_mask) == '0))
        else $error("button both fell and rose in one item");

    a_steady_level: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (((result.held_mask & result.level_mask) == '0) &&
                          ((result.up_mask & ~result.level_mask) == '0)))
        else $error("steady mask disagrees with accepted level");
`endif

endmodule

/* verif/tb_multi_button_debounce_events_top.sv */
// ----------------------------------------------------------------------------
// tb_multi_button_debounce_events_top: self-checking bench for the debouncer
// Feeds timed pin samples through the valid/ready sample channel, predicts the
// eight event masks per sample and checks every result item in order.
// ----------------------------------------------------------------------------
module tb_multi_button_debounce_events_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB = mbde_pkg::NUM_BUTTONS_DEF;

    // Evaluated flag groups {cur, stable, acc, chg}
    localparam logic [3:0] EV_FELL = 4'b0101;
    localparam logic [3:0] EV_ROSE = 4'b1111;
    localparam logic [3:0] EV_UP   = 4'b1110;
    localparam logic [3:0] EV_HELD = 4'b0100;

    // Receiver behavior while it is not in a long hold-off
    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the per-button state and registers,
    // works out the masks for every accepted sample and checks results in order.
    // ------------------------------------------------------------------------
    class mask_scoreboard;
        mbde_pkg::cfg_t      regs;
        mbde_pkg::flags_t    btn [NB];
        logic [31:0]         stamp [NB];      // debounce start or acceptance time
        logic [31:0]         tick_base [NB];  // base of the repeat tick
        mbde_pkg::result_t   expected_masks [$];
        int                  errors;

        function new();
            int n;
            regs.debounce_ms      = mbde_pkg::DEBOUNCE_RST;
            regs.held_until_ms    = mbde_pkg::HELD_UNTIL_RST;
            regs.up_until_ms      = mbde_pkg::UP_UNTIL_RST;
            regs.tick_interval_ms = mbde_pkg::TICK_INTERVAL_RST;
            regs.event_enable     = mbde_pkg::EVENT_ENABLE_RST;
            for (n = 0; n < NB; n++)
            begin
                btn[n]       = mbde_pkg::FLAGS_RST;
                stamp[n]     = '0;
                tick_base[n] = '0;
            end
            errors = 0;
        endfunction

        function void set_reg(logic [mbde_pkg::REG_IDX_W-1:0] idx,
                              logic [mbde_pkg::CFG_W-1:0] data);
            case (idx)
                mbde_pkg::REG_DEBOUNCE:      regs.debounce_ms      = data;
                mbde_pkg::REG_HELD_UNTIL:    regs.held_until_ms    = data;
                mbde_pkg::REG_UP_UNTIL:      regs.up_until_ms      = data;
                mbde_pkg::REG_TICK_INTERVAL: regs.tick_interval_ms = data;
                mbde_pkg::REG_EVENT_ENABLE:  regs.event_enable     = data[2:0];
                default: ;
            endcase
        endfunction

        function void note_sample(mbde_pkg::sample_t s);
            mbde_pkg::result_t r;
            mbde_pkg::flags_t  f;
            logic [3:0]        ev;
            logic [31:0]       elapsed;
            logic [31:0]       since;
            int                n;
            r = '0;
            // Update every button first
            for (n = 0; n < NB; n++)
            begin
                f       = btn[n];
                f.chg   = 1'b0;
                f.cur   = s.pin_levels[n];
                elapsed = s.now_ms - stamp[n];
                if (f.cur == f.acc)
                    f.stable = 1'b1;
                else if (f.stable)
                begin
                    f.stable = 1'b0;
                    stamp[n] = s.now_ms;
                end
                else if (elapsed >= regs.debounce_ms)
                begin
                    f.stable     = 1'b1;
                    f.chg        = 1'b1;
                    f.acc        = f.cur;
                    f.used       = 1'b0;
                    stamp[n]     = s.now_ms;
                    tick_base[n] = s.now_ms;
                end
                btn[n] = f;
            end
            // Then read events from the updated flags
            for (n = 0; n < NB; n++)
            begin
                f       = btn[n];
                ev      = {f.cur, f.stable, f.acc, f.chg};
                elapsed = s.now_ms - stamp[n];
                r.level_mask[n] = f.acc;
                r.fell_mask[n]  = (ev == EV_FELL);
                r.rose_mask[n]  = (ev == EV_ROSE);
                r.up_mask[n]    = (ev == EV_UP);
                r.held_mask[n]  = (ev == EV_HELD);
                if (regs.event_enable[mbde_pkg::EN_HELD_LONG] && ev == EV_HELD && !f.used
                    && elapsed >= regs.held_until_ms)
                begin
                    f.used = 1'b1;
                    r.held_long_mask[n] = 1'b1;
                end
                if (regs.event_enable[mbde_pkg::EN_UP_LONG] && ev == EV_UP && !f.used
                    && elapsed >= regs.up_until_ms)
                begin
                    f.used = 1'b1;
                    r.up_long_mask[n] = 1'b1;
                end
                if (regs.event_enable[mbde_pkg::EN_TICK] && ev == EV_HELD)
                begin
                    since = s.now_ms - tick_base[n];
                    if (since >= regs.tick_interval_ms && !f.tick)
                    begin
                        f.tick       = 1'b1;
                        tick_base[n] = tick_base[n] + regs.tick_interval_ms;
                        r.tick_mask[n] = 1'b1;
                    end
                    else if (since < regs.tick_interval_ms && f.tick)
                        f.tick = 1'b0;
                end
                btn[n] = f;
            end
            expected_masks.push_back(r);
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= 10)
                $display("%t %s", $realtime, msg);
        endfunction

        function void check_masks(mbde_pkg::result_t got);
            mbde_pkg::result_t want;
            string             fields [8];
            int                k;
            int                top;
            fields = '{"level", "fell", "rose", "up", "held", "held_long", "up_long", "tick"};
            if (expected_masks.size() == 0)
            begin
                note_failure($sformatf("result with no prediction waiting: %h", got));
                return;
            end
            want = expected_masks.pop_front();
            for (k = 0; k < 8; k++)
            begin
                top = $bits(mbde_pkg::result_t) - 1 - 16 * k;
                if (got[top -: 16] !== want[top -: 16])
                    note_failure($sformatf("%s_mask mismatch: expected %h, got %h",
                                           fields[k], want[top -: 16], got[top -: 16]));
            end
        endfunction

        function int pending();
            return expected_masks.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block under test
    // ------------------------------------------------------------------------
    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           sample_valid;
    logic                           sample_ready;
    mbde_pkg::sample_t              sample;
    logic                           result_valid;
    logic                           result_ready;
    mbde_pkg::result_t              result;
    logic                           wr_en;
    logic [mbde_pkg::REG_IDX_W-1:0] wr_index;
    logic [mbde_pkg::CFG_W-1:0]     wr_data;

    mask_scoreboard board;

    // Stimulus state carried across items: the raw pin pattern and the clock
    logic [15:0] pins_now;
    logic [31:0] clock_ms;

    multi_button_debounce_events_top #(
        .NUM_BUTTONS (NB)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Driving tasks: every change lands on a falling edge
    // ------------------------------------------------------------------------

    // Offer one item, hold it until the block takes it, then note it.
    // Returns on the falling edge after acceptance.
    task drive_sample(input mbde_pkg::sample_t s);
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (!sample_ready)
            @(posedge clk);
        board.note_sample(s);
        @(negedge clk);
    endtask

    // Drop valid for a gap between bursts
    task idle_sender(input int cycles);
        if (cycles > 0)
        begin
            sample_valid <= 1'b0;
            repeat (cycles) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted result has been taken
    task drain_results();
        sample_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
    endtask

    // Write all five registers back to back; only call while the block is idle
    task apply_config(input mbde_pkg::cfg_t c);
        logic [mbde_pkg::REG_IDX_W-1:0] idx [5];
        logic [mbde_pkg::CFG_W-1:0]     data [5];
        int                             i;
        idx[0] = mbde_pkg::REG_DEBOUNCE;       data[0] = c.debounce_ms;
        idx[1] = mbde_pkg::REG_HELD_UNTIL;     data[1] = c.held_until_ms;
        idx[2] = mbde_pkg::REG_UP_UNTIL;       data[2] = c.up_until_ms;
        idx[3] = mbde_pkg::REG_TICK_INTERVAL;  data[3] = c.tick_interval_ms;
        idx[4] = mbde_pkg::REG_EVENT_ENABLE;
        data[4] = {{(mbde_pkg::CFG_W-3){1'b0}}, c.event_enable};
        for (i = 0; i < 5; i++)
        begin
            wr_en    <= 1'b1;
            wr_index <= idx[i];
            wr_data  <= data[i];
            board.set_reg(idx[i], data[i]);
            @(negedge clk);
        end
        wr_en <= 1'b0;
    endtask

    // Random sample stream in bursts. Most items move time forward by a small
    // step and flip a few pins, so levels persist long enough to be accepted
    // and long-press and tick events come up. The rest are pin noise and
    // jumps of the clock, forward or past the wrap.
    task run_phase(input int count, input int step_max, input int flip_odds,
                   input logic [31:0] t0);
        mbde_pkg::sample_t s;
        logic [15:0]       flips;
        int                burst;
        int                pick;
        int                k;
        int                b;
        burst    = 0;
        clock_ms = t0;
        for (k = 0; k < count; k++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 40);
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
            end
            burst--;
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                clock_ms = clock_ms + $urandom_range(0, step_max);
                flips = '0;
                for (b = 0; b < 16; b++)
                    flips[b] = ($urandom_range(1, flip_odds) == 1);
                pins_now = pins_now ^ flips;
            end
            else if (pick < 95)
            begin
                pins_now = 16'($urandom);
                clock_ms = clock_ms + $urandom_range(0, 3);
            end
            else
                clock_ms = clock_ms + $urandom;
            s.pin_levels = pins_now;
            s.now_ms     = clock_ms;
            drive_sample(s);
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: changes ready on falling edges. It switches between open,
    // random and sparse stretches, and every so often holds off for a long
    // run of cycles on its own count so the block backs up into the sample side.
    // ------------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       stretch;
        int       hold;
        int       cyc;
        mode    = RX_OPEN;
        stretch = 0;
        hold    = 0;
        cyc     = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (cyc % 12000 == 3000)
                hold = 400;
            if (stretch == 0)
            begin
                mode    = rx_mode_t'($urandom_range(0, 2));
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            if (hold > 0)
            begin
                hold--;
                result_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   result_ready <= 1'b1;
                    RX_RANDOM: result_ready <= 1'($urandom_range(0, 1));
                    default:   result_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check every result item on the edge that takes it
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_masks(result);
    end

    // Hard stop for a hung handshake
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        mbde_pkg::sample_t directed [$];
        mbde_pkg::cfg_t    c;
        int                i;
        int                p;

        board = new();
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        wr_en        = 1'b0;
        wr_index     = '0;
        wr_data      = '0;
        pins_now     = 16'hFFFF;
        clock_ms     = '0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under reset registers (all long events and ticks off):
        // full press, steady hold, a bounce that returns before acceptance,
        // a release whose debounce straddles the time wrap, mixed patterns.
        directed.push_back('{pin_levels: 16'hFFFF, now_ms: 32'd0});
        directed.push_back('{pin_levels: 16'h0000, now_ms: 32'd5});
        directed.push_back('{pin_levels: 16'h0000, now_ms: 32'd24});
        directed.push_back('{pin_levels: 16'h0000, now_ms: 32'd25});
        directed.push_back('{pin_levels: 16'h0000, now_ms: 32'd40});
        directed.push_back('{pin_levels: 16'hFFFF, now_ms: 32'd41});
        directed.push_back('{pin_levels: 16'h0000, now_ms: 32'd70});
        directed.push_back('{pin_levels: 16'h00FF, now_ms: 32'hFFFF_FFF0});
        directed.push_back('{pin_levels: 16'h00FF, now_ms: 32'hFFFF_FFFF});
        directed.push_back('{pin_levels: 16'h00FF, now_ms: 32'h0000_0003});
        directed.push_back('{pin_levels: 16'h00FF, now_ms: 32'h0000_0004});
        directed.push_back('{pin_levels: 16'hA5A5, now_ms: 32'h0000_0010});
        directed.push_back('{pin_levels: 16'h5A5A, now_ms: 32'h0000_0030});
        directed.push_back('{pin_levels: 16'h5A5A, now_ms: 32'h0000_0050});
        directed.push_back('{pin_levels: 16'hFFFF, now_ms: 32'h7FFF_FFFF});
        directed.push_back('{pin_levels: 16'hFFFF, now_ms: 32'h8000_0000});
        for (i = 0; i < directed.size(); i++)
            drive_sample(directed[i]);
        drain_results();

        // Reset registers, random stream
        run_phase(150, 8, 12, $urandom);
        drain_results();

        // Low extremes: instant acceptance, instant long events, tick every ms
        c = '{debounce_ms: 16'd0, held_until_ms: 16'd0, up_until_ms: 16'd0,
              tick_interval_ms: 16'd1, event_enable: 3'b111};
        apply_config(c);
        run_phase(150, 4, 10, $urandom);
        drain_results();

        // High extremes with large time steps running through the wrap
        c = '{debounce_ms: 16'hFFFF, held_until_ms: 16'hFFFF, up_until_ms: 16'hFFFF,
              tick_interval_ms: 16'hFFFF, event_enable: 3'b111};
        apply_config(c);
        run_phase(100, 30000, 10, 32'hFFF0_0000);
        drain_results();

        // Zero tick interval: one tick after acceptance, then latched
        c = '{debounce_ms: 16'd3, held_until_ms: 16'd40, up_until_ms: 16'd40,
              tick_interval_ms: 16'd0, event_enable: 3'b100};
        apply_config(c);
        run_phase(100, 10, 15, $urandom);
        drain_results();

        // Random register settings
        for (p = 0; p < 4; p++)
        begin
            c.debounce_ms      = 16'($urandom_range(0, 40));
            c.held_until_ms    = 16'($urandom_range(0, 600));
            c.up_until_ms      = 16'($urandom_range(0, 600));
            c.tick_interval_ms = ($urandom_range(0, 4) == 0) ? 16'd0
                                 : 16'($urandom_range(1, 200));
            c.event_enable     = 3'($urandom_range(0, 7));
            apply_config(c);
            run_phase(125, 20, $urandom_range(8, 40), $urandom);
            drain_results();
        end

        // Let any stray result show up before the verdict
        repeat (40) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* sim.f */
src/mbde_pkg.sv
src/mbde_unit.sv
src/multi_button_debounce_events_top.sv
verif/tb_multi_button_debounce_events_top.sv
